@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/arct_pkg.sv @@
// ----------------------------------------------------------------------------
// ALOHA collision tracker package
// Beat types, register map and fixed widths shared by the tracker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arct_pkg;

  localparam int IN_ID_W   = 32;
  localparam int IN_TIME_W = 48;
  localparam int DUR_W     = 32;
  localparam int PWR_W     = 32;
  localparam int SUM_W     = 40;
  localparam int THR_W     = 35;
  localparam int SIR_W     = 42;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  localparam logic REG_CAPTURE_THRESHOLD = 1'b0;

  localparam logic [THR_W-1:0] THR_RESET = 35'h2_0000_0000;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [IN_ID_W-1:0]   packet_id;
    logic [IN_TIME_W-1:0] now_time;
    logic [DUR_W-1:0]     tx_duration;
    logic [PWR_W-1:0]     sig_pwr;
  } in_beat_t;

  typedef struct packed {
    logic overlap_seen;
    logic delivered;
    logic discarded;
  } out_beat_t;

endpackage

@@ hw/rtl/arct_regs.sv @@
// ----------------------------------------------------------------------------
// ALOHA collision tracker register bank
// APB-style access to the signed capture threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arct_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [arct_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [arct_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [arct_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [arct_pkg::THR_W-1:0]       thr
);

  logic [arct_pkg::THR_W-1:0] thr_r;
  logic [arct_pkg::THR_W-1:0] thr_nxt;
  logic                       wr_en;
  logic                       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[arct_pkg::CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en && (reg_idx == arct_pkg::REG_CAPTURE_THRESHOLD)) begin
      thr_nxt = pwdata[arct_pkg::THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= arct_pkg::THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign prdata = {{(arct_pkg::CFG_DATA_W - arct_pkg::THR_W){1'b0}}, thr_r};
  assign thr    = thr_r;

  `ASSERT_NXT(a_bad_index_ignored, wr_en && (reg_idx != arct_pkg::REG_CAPTURE_THRESHOLD),
              $stable(thr_r))
  `ASSERT_NXT(a_no_write_holds, !wr_en, $stable(thr_r))
  `ASSERT_NXT(a_write_lands, wr_en && (reg_idx == arct_pkg::REG_CAPTURE_THRESHOLD),
              thr_r == $past(pwdata[arct_pkg::THR_W-1:0]))

endmodule

@@ hw/rtl/arct_core.sv @@
// ----------------------------------------------------------------------------
// ALOHA collision tracker core
// Busy-period state and the combinational start and finish evaluation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arct_core #(
  parameter int TIME_BITS = 48,
  parameter int ID_BITS   = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  arct_pkg::in_beat_t         beat,
  input  logic [arct_pkg::THR_W-1:0] thr,
  output arct_pkg::out_beat_t        result
);

  localparam int IdKeep   = (ID_BITS < arct_pkg::IN_ID_W) ? ID_BITS : arct_pkg::IN_ID_W;
  localparam int TimeKeep = (TIME_BITS < arct_pkg::IN_TIME_W) ? TIME_BITS
                                                               : arct_pkg::IN_TIME_W;
  localparam int FinW     = ((TIME_BITS > arct_pkg::DUR_W) ? TIME_BITS
                                                           : arct_pkg::DUR_W) + 1;
  localparam int SumW     = arct_pkg::SUM_W;
  localparam int SirW     = arct_pkg::SIR_W;
  localparam int ThrW     = arct_pkg::THR_W;
  localparam int PwrW     = arct_pkg::PWR_W;

  logic                 active_r, active_nxt;
  logic [ID_BITS-1:0]   owner_r, owner_nxt;
  logic [TIME_BITS-1:0] pend_r, pend_nxt;
  logic                 mark_r, mark_nxt;
  logic [SumW-1:0]      sum_r, sum_nxt;

  logic [ID_BITS-1:0]   id_v;
  logic [TIME_BITS-1:0] now_v;
  logic [FinW-1:0]      fin_raw;
  logic [TIME_BITS-1:0] fin;
  logic [SumW:0]        sum_add;
  logic [SumW-1:0]      sum_sat;
  logic                 overlap;
  logic signed [SirW-1:0] sir;
  logic signed [SirW-1:0] thr_ext;
  logic                 dropped;
  logic                 is_owner;

  assign id_v  = ID_BITS'(beat.packet_id[IdKeep-1:0]);
  assign now_v = TIME_BITS'(beat.now_time[TimeKeep-1:0]);

  assign fin_raw = FinW'(now_v) + FinW'(beat.tx_duration);
  assign fin     = (fin_raw[FinW-1:TIME_BITS] != '0) ? {TIME_BITS{1'b1}}
                                                     : fin_raw[TIME_BITS-1:0];

  assign sum_add = {1'b0, sum_r} + (SumW + 1)'(beat.sig_pwr);
  assign sum_sat = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];

  assign overlap = active_r && (now_v < pend_r);

  assign sir     = $signed({{(SirW - PwrW - 1){1'b0}}, beat.sig_pwr, 1'b0})
                 - $signed({{(SirW - SumW){1'b0}}, sum_r});
  assign thr_ext = $signed({{(SirW - ThrW){thr[ThrW-1]}}, thr});
  assign dropped = mark_r && (sir < thr_ext);

  assign is_owner = active_r && (owner_r == id_v);

  always_comb begin
    active_nxt = active_r;
    owner_nxt  = owner_r;
    pend_nxt   = pend_r;
    mark_nxt   = mark_r;
    sum_nxt    = sum_r;
    result     = '0;
    if (beat.action == arct_pkg::ACT_START) begin
      result.overlap_seen = overlap;
      if (overlap) begin
        mark_nxt = 1'b1;
        sum_nxt  = sum_sat;
      end
      if (!active_r || (fin >= pend_r)) begin
        active_nxt = 1'b1;
        owner_nxt  = id_v;
        pend_nxt   = fin;
        sum_nxt    = SumW'(beat.sig_pwr);
      end
    end else begin
      result.delivered = !dropped;
      result.discarded = dropped;
      if (is_owner) begin
        active_nxt = 1'b0;
        pend_nxt   = now_v;
        mark_nxt   = 1'b0;
        sum_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      owner_r  <= '0;
      pend_r   <= '0;
      mark_r   <= 1'b0;
      sum_r    <= '0;
    end else if (step_en) begin
      active_r <= active_nxt;
      owner_r  <= owner_nxt;
      pend_r   <= pend_nxt;
      mark_r   <= mark_nxt;
      sum_r    <= sum_nxt;
    end
  end

  `ASSERT_IMP(a_mark_needs_period, mark_r, active_r)
  `ASSERT_IMP(a_idle_sum_zero, !active_r, sum_r == '0)
  `ASSERT_NXT(a_hold_without_step, !step_en,
              $stable(active_r) && $stable(pend_r) && $stable(sum_r) && $stable(mark_r))

endmodule

@@ hw/rtl/aloha_rx_collision_tracker.sv @@
// ----------------------------------------------------------------------------
// ALOHA receive collision tracker
// Follows one busy period on a shared channel and decides delivery or drop
// with capture for each reception event.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Beat
//  in_      input      in_valid/in_ready  in_beat_t, one event
//  out_     output     out_valid/out_ready out_beat_t, one result per event
//  cfg      input      APB psel/penable   capture threshold, 8-byte slot
//
// An event waits in the input register, where the state update and the result
// are formed, and moves to the output register once the output is free, which
// raises out_valid; one event per cycle while out_ready keeps the output free.
// Reset is synchronous and active low; it clears the period and sets the
// threshold to its disabled value. A stalled output holds its beat while one
// more event waits in the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aloha_rx_collision_tracker #(
  parameter int TIME_BITS = 48,
  parameter int ID_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  arct_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output arct_pkg::out_beat_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arct_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [arct_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [arct_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic                       inp_vld_r;
  arct_pkg::in_beat_t         inp_r;
  logic                       out_vld_r;
  arct_pkg::out_beat_t        out_r;
  arct_pkg::out_beat_t        result;
  logic [arct_pkg::THR_W-1:0] thr;
  logic                       out_free;
  logic                       advance;
  logic                       in_take;

  assign out_free = !out_vld_r || out_ready;
  assign advance  = inp_vld_r && out_free;
  assign in_ready = !inp_vld_r || out_free;
  assign in_take  = in_valid && in_ready;

  arct_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  arct_core #(
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .beat    (inp_r),
    .thr     (thr),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        inp_vld_r <= 1'b1;
      end else if (advance) begin
        inp_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inp_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `ASSERT_IMP(a_result_onehot, out_vld_r,
              $onehot0({out_r.overlap_seen, out_r.delivered, out_r.discarded}))
  `ASSERT_NXT(a_waiting_beat_kept, inp_vld_r && !out_free, inp_vld_r)
  `ASSERT_NXT(a_advance_fills_out, advance, out_vld_r)

endmodule
